FILE: src/rrq_pkg.sv
// Shared types, constants and the sine table generator for the radial run-to-quad block.
package rrq_pkg;

  localparam int unsigned MAX_BINS_DEF    = 2048;
  localparam int unsigned TRIG_DEPTH_DEF  = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned BSIZE_W = 16;
  localparam int unsigned RBINS_W = 12;
  localparam int unsigned LEN_W   = 12;
  // start distance at the largest bin count (4096 bins of 16 bits)
  localparam int unsigned DIST_W  = 28;
  localparam int unsigned COORD_W = 28;
  localparam int unsigned QNUM_W  = 32;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_STEP   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BINS = 1'd1;

  localparam logic [BSIZE_W-1:0] BIN_STEP_RST   = 16'd256;
  localparam logic [RBINS_W-1:0] RANGE_BINS_RST = 12'd1024;

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned TaylorDiv [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                  64'd110, 64'd156, 64'd210};

  // one finished run waiting for the back end
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [LEN_W-1:0]   run_len;
    logic [DIST_W-1:0]  start_dist;
    logic [BSIZE_W-1:0] bin_step;
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] end_angle;
    logic [QNUM_W-1:0]  quad_num;
  } rrq_job_t;

  typedef struct packed {
    logic push;
    logic first_bin;
  } rrq_front_st_t;

  // Q1.15 sine of a 32-bit phase; elaboration-time only, fills the tables
  function automatic logic signed [TRIG_W-1:0] phase_sine(input logic [31:0] a);
    logic [1:0]          q;
    logic [63:0]         r;
    logic [63:0]         x;
    logic [63:0]         t;
    logic signed [63:0]  sum;
    logic signed [63:0]  v;
    q = a[31:30];
    r = {34'd0, a[29:0]};
    if (q[0]) begin
      r = 64'h4000_0000 - r;
    end
    x   = (r * HalfPiQ30) >> 30;
    t   = x;
    sum = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / TaylorDiv[n];
      if (n % 2 == 1) begin
        sum = sum - signed'(t);
      end else begin
        sum = sum + signed'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    if (q[1]) begin
      v = -v;
    end
    return v[TRIG_W-1:0];
  endfunction

endpackage

FILE: src/rrq_if.sv
// Valid/ready channel interfaces for range bins and quads.
interface rrq_bin_if import rrq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] bin_level;
  logic [ANGLE_W-1:0] start_angle;
  logic [ANGLE_W-1:0] end_angle;

  modport source (output valid, bin_level, start_angle, end_angle, input ready);
  modport sink   (input valid, bin_level, start_angle, end_angle, output ready);
endinterface

interface rrq_quad_if import rrq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] inner_end_x;
  logic signed [COORD_W-1:0] inner_end_y;
  logic signed [COORD_W-1:0] outer_end_x;
  logic signed [COORD_W-1:0] outer_end_y;
  logic signed [COORD_W-1:0] outer_start_x;
  logic signed [COORD_W-1:0] outer_start_y;
  logic signed [COORD_W-1:0] inner_start_x;
  logic signed [COORD_W-1:0] inner_start_y;
  logic [LEVEL_W-1:0]        run_level;
  logic [QNUM_W-1:0]         quad_number;

  modport source (output valid, inner_end_x, inner_end_y, outer_end_x, outer_end_y,
                  outer_start_x, outer_start_y, inner_start_x, inner_start_y,
                  run_level, quad_number, input ready);
  modport sink   (input valid, inner_end_x, inner_end_y, outer_end_x, outer_end_y,
                  outer_start_x, outer_start_y, inner_start_x, inner_start_y,
                  run_level, quad_number, output ready);
endinterface

FILE: src/rrq_front.sv
// Run tracker: one bin per cycle while the job queue has room; pushes finished runs.
module rrq_front import rrq_pkg::*; #(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BSIZE_W-1:0] bin_step_i,
  input  logic [RBINS_W-1:0] range_bins_i,
  input  logic               bin_valid_i,
  input  logic [LEVEL_W-1:0] bin_level_i,
  input  logic [ANGLE_W-1:0] start_angle_i,
  input  logic [ANGLE_W-1:0] end_angle_i,
  input  logic               q_full_i,
  output logic               bin_ready_o,
  output rrq_front_st_t      st_o,
  output rrq_job_t           job_o
);

  localparam int unsigned PW = $clog2(MAX_BINS);
  localparam int unsigned CW = PW + 1;

  logic [LEVEL_W-1:0] run_val_q, run_val_d;
  logic [LEN_W-1:0]   run_len_q, run_len_d;
  logic [DIST_W-1:0]  start_q, start_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [QNUM_W-1:0]  qnum_q, qnum_d;

  logic               take;
  logic [RBINS_W:0]   eff_wide;
  logic [CW-1:0]      eff;
  logic [CW-1:0]      pos_inc;
  logic [PW+BSIZE_W-1:0] pos_dist;
  logic               first;
  logic               push;

  assign bin_ready_o = !q_full_i;
  assign take        = bin_valid_i && !q_full_i;
  assign first       = (pos_q == '0);

  // effective bins per radial: zero counts as one, clipped at MAX_BINS
  always_comb begin
    eff_wide = {1'b0, range_bins_i};
    if (range_bins_i == '0) begin
      eff_wide = (RBINS_W+1)'(1);
    end else if (eff_wide > (RBINS_W+1)'(MAX_BINS)) begin
      eff_wide = (RBINS_W+1)'(MAX_BINS);
    end
    eff = CW'(eff_wide);
  end

  assign pos_inc  = {1'b0, pos_q} + CW'(1);
  assign pos_dist = pos_q * bin_step_i;
  assign push     = take && !first && (bin_level_i != run_val_q);

  always_comb begin
    run_val_d = run_val_q;
    run_len_d = run_len_q;
    start_d   = start_q;
    pos_d     = pos_q;
    qnum_d    = qnum_q;
    if (take) begin
      if (first) begin
        run_val_d = bin_level_i;
        run_len_d = LEN_W'(1);
        start_d   = DIST_W'(bin_step_i);
      end else if (bin_level_i == run_val_q) begin
        run_len_d = run_len_q + LEN_W'(1);
      end else begin
        run_val_d = bin_level_i;
        run_len_d = LEN_W'(1);
        start_d   = DIST_W'(pos_dist);
        qnum_d    = qnum_q + QNUM_W'(1);
      end
      pos_d = (pos_inc >= eff) ? '0 : PW'(pos_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_val_q <= '0;
      run_len_q <= '0;
      start_q   <= '0;
      pos_q     <= '0;
      qnum_q    <= '0;
    end else begin
      run_val_q <= run_val_d;
      run_len_q <= run_len_d;
      start_q   <= start_d;
      pos_q     <= pos_d;
      qnum_q    <= qnum_d;
    end
  end

  assign st_o.push      = push;
  assign st_o.first_bin = first;

  assign job_o.level       = run_val_q;
  assign job_o.run_len     = run_len_q;
  assign job_o.start_dist  = start_q;
  assign job_o.bin_step    = bin_step_i;
  assign job_o.start_angle = start_angle_i;
  assign job_o.end_angle   = end_angle_i;
  assign job_o.quad_num    = qnum_q;

endmodule

FILE: src/rrq_fifo.sv
// Short job queue between run tracker and quad builder.
module rrq_fifo import rrq_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rrq_job_t data_i,
  input  logic     pop_i,
  output rrq_job_t data_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  rrq_job_t      mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == NW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      cnt_q <= cnt_q + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

FILE: src/rrq_back.sv
// Quad builder: trig lookup, outer distance and eight corners on one multiplier.
module rrq_back import rrq_pkg::*; #(
  parameter int unsigned TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_empty_i,
  input  rrq_job_t job_i,
  output logic     pop_o,
  rrq_quad_if.source quad_o
);

  localparam int unsigned IW  = $clog2(TRIG_TABLE_DEPTH);
  localparam int unsigned OW  = DIST_W + 1;
  localparam int unsigned PRW = OW + 1 + TRIG_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_SUM, ST_MUL, ST_HOLD
  } state_e;

  logic signed [TRIG_W-1:0] sin_rom [TRIG_TABLE_DEPTH];
  logic signed [TRIG_W-1:0] cos_rom [TRIG_TABLE_DEPTH];

  for (genvar g = 0; g < TRIG_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [31:0] Phase = 32'((64'(g) << 32) / TRIG_TABLE_DEPTH);
    assign sin_rom[g] = phase_sine(Phase);
    assign cos_rom[g] = phase_sine(Phase + 32'h4000_0000);
  end

  state_e                   state_q;
  rrq_job_t                 job_q;
  logic signed [TRIG_W-1:0] sin_e_q, cos_e_q, sin_s_q, cos_s_q;
  logic [DIST_W-1:0]        len_dist_q;
  logic [OW-1:0]            outer_q;
  logic [3:0]               k_q;
  logic signed [PRW-1:0]    mprod_q;
  logic signed [COORD_W-1:0] coord_q [8];
  logic                     out_valid_q;

  logic [31:0]              ie_full, is_full;
  logic [IW-1:0]            ie, is_idx;
  logic [OW-1:0]            dist_sel;
  logic signed [TRIG_W-1:0] trig_sel;
  logic signed [PRW-1:0]    mprod;
  logic signed [PRW-1:0]    rounded;
  logic                     out_free;
  logic                     out_load;

  assign ie_full = 32'(job_q.end_angle) * 32'(TRIG_TABLE_DEPTH);
  assign is_full = 32'(job_q.start_angle) * 32'(TRIG_TABLE_DEPTH);
  assign ie      = ie_full[IW+15:16];
  assign is_idx  = is_full[IW+15:16];

  // corner order: inner/outer at end angle, then outer/inner at start angle
  always_comb begin
    dist_sel = OW'(job_q.start_dist);
    trig_sel = cos_e_q;
    case (k_q[2:0])
      3'd0: trig_sel = cos_e_q;
      3'd1: trig_sel = sin_e_q;
      3'd2: begin dist_sel = outer_q; trig_sel = cos_e_q; end
      3'd3: begin dist_sel = outer_q; trig_sel = sin_e_q; end
      3'd4: begin dist_sel = outer_q; trig_sel = cos_s_q; end
      3'd5: begin dist_sel = outer_q; trig_sel = sin_s_q; end
      3'd6: trig_sel = cos_s_q;
      3'd7: trig_sel = sin_s_q;
      default: trig_sel = cos_e_q;
    endcase
  end

  assign mprod    = signed'({1'b0, dist_sel}) * trig_sel;
  assign rounded  = mprod_q + PRW'(16384);
  assign out_free = !out_valid_q || quad_o.ready;
  assign out_load = (state_q == ST_HOLD) && out_free;
  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i;

  always_ff @(posedge clk_i) begin
    sin_e_q <= sin_rom[ie];
    cos_e_q <= cos_rom[ie];
    sin_s_q <= sin_rom[is_idx];
    cos_s_q <= cos_rom[is_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= ST_IDLE;
      out_valid_q          <= 1'b0;
      k_q                  <= '0;
      job_q                <= '0;
      len_dist_q           <= '0;
      outer_q              <= '0;
      mprod_q              <= '0;
      coord_q              <= '{default: '0};
      quad_o.inner_end_x   <= '0;
      quad_o.inner_end_y   <= '0;
      quad_o.outer_end_x   <= '0;
      quad_o.outer_end_y   <= '0;
      quad_o.outer_start_x <= '0;
      quad_o.outer_start_y <= '0;
      quad_o.inner_start_x <= '0;
      quad_o.inner_start_y <= '0;
      quad_o.run_level     <= '0;
      quad_o.quad_number   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && quad_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            job_q   <= job_i;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          len_dist_q <= DIST_W'(job_q.bin_step * job_q.run_len);
          state_q    <= ST_SUM;
        end
        ST_SUM: begin
          outer_q <= OW'(job_q.start_dist) + OW'(len_dist_q);
          k_q     <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          mprod_q <= mprod;
          if (k_q != '0) begin
            coord_q[k_q[2:0] - 3'd1] <= rounded[COORD_W+14:15];
          end
          k_q <= k_q + 4'd1;
          if (k_q == 4'd8) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            quad_o.inner_end_x   <= coord_q[0];
            quad_o.inner_end_y   <= coord_q[1];
            quad_o.outer_end_x   <= coord_q[2];
            quad_o.outer_end_y   <= coord_q[3];
            quad_o.outer_start_x <= coord_q[4];
            quad_o.outer_start_y <= coord_q[5];
            quad_o.inner_start_x <= coord_q[6];
            quad_o.inner_start_y <= coord_q[7];
            quad_o.run_level     <= job_q.level;
            quad_o.quad_number   <= job_q.quad_num;
            state_q              <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign quad_o.valid = out_valid_q;

endmodule

FILE: src/radar_radial_run_to_quads.sv
// A run is pushed on the bin that ends it; the back end pops it and steps LOAD, SUM, MUL, HOLD.
// Throughput: one range bin per cycle while the four-entry job queue has room; the back end
//   builds one quad at a time on its single shared corner multiplier (8 products).
// Reset: asynchronous, active low; run state, counters, queue and output valid clear,
//   bin step returns to 256 and range_bins to 1024. No clearing pass.
module radar_radial_run_to_quads import rrq_pkg::*; #(
  parameter int unsigned MAX_BINS         = MAX_BINS_DEF,
  parameter int unsigned TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BSIZE_W-1:0]   cfg_data_i,
  rrq_bin_if.sink              bin_i,
  rrq_quad_if.source           quad_o
);

  // config registers, to be written only while the block is idle; the block does not enforce it
  logic [BSIZE_W-1:0] bin_step_q;
  logic [RBINS_W-1:0] range_bins_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_step_q   <= BIN_STEP_RST;
      range_bins_q <= RANGE_BINS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BIN_STEP:   bin_step_q   <= cfg_data_i;
        CFG_RANGE_BINS: range_bins_q <= cfg_data_i[RBINS_W-1:0];
        default: ;
      endcase
    end
  end

  rrq_front_st_t front_st;
  rrq_job_t      push_job, head_job;
  logic          q_full, q_empty, q_pop;

  // front: run tracking, one compare per word
  rrq_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bin_step_i    (bin_step_q),
    .range_bins_i  (range_bins_q),
    .bin_valid_i   (bin_i.valid),
    .bin_level_i   (bin_i.bin_level),
    .start_angle_i (bin_i.start_angle),
    .end_angle_i   (bin_i.end_angle),
    .q_full_i      (q_full),
    .bin_ready_o   (bin_i.ready),
    .st_o          (front_st),
    .job_o         (push_job)
  );

  // finished runs wait here so the front keeps streaming while a quad is built
  rrq_fifo #(
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_st.push),
    .data_i  (push_job),
    .pop_i   (q_pop),
    .data_o  (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: trig lookup and corner products
  rrq_back #(
    .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .job_i     (head_job),
    .pop_o     (q_pop),
    .quad_o    (quad_o)
  );

  // a run is never queued into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(front_st.push && q_full))
    else $error("run pushed into full queue");

  // the first bin of a radial never ends a run
  a_first_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bin_i.valid && bin_i.ready && front_st.first_bin) |-> !front_st.push)
    else $error("radial start emitted a quad");

  // the back only takes a job that is there
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
